/* rtl/ftpw_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Frame time percentile window package
// Shared widths, codes and the state encoding of the percentile window core.
// ----------------------------------------------------------------------------
package ftpw_pkg;

   localparam int MAX_SAMPLES = 256;
   localparam int IDX_W       = 8;
   localparam int CNT_W       = 9;
   localparam int GPU_PASSES  = 8;
   localparam int SERIES      = 10;
   localparam int SER_W       = 4;
   localparam int TIME_W      = 24;
   localparam int WARM_W      = 16;
   localparam int FRAME_W     = 17;
   localparam int OP_W        = 2;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 16;
   localparam int ADDR_W      = SER_W + IDX_W;
   localparam int STORE_DEPTH = SERIES * MAX_SAMPLES;
   localparam int DIV_W       = 31;
   localparam int REM_W       = 7;
   localparam int DIVISOR     = 100;
   localparam int PROD_W      = 2 * DIV_W;
   // ceil(2^37 / 100): exact quotient for every dividend below 2^31
   localparam int RECIP_MUL   = 1374389535;
   localparam int RECIP_SHIFT = 37;
   localparam int PCT_MED     = 50;
   localparam int PCT_HIGH    = 95;
   localparam int SCALED_W    = 15;
   localparam int RANKS       = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_WARMUP = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW = 2'd1;

   typedef enum logic [OP_W-1:0] {
      OP_OBSERVE   = 2'd0,
      OP_SUMMARIZE = 2'd1,
      OP_CLEAR     = 2'd2
   } op_type;

   typedef enum logic [13:0] {
      ST_IDLE = 14'b00000000000001,
      ST_OBS  = 14'b00000000000010,
      ST_SER  = 14'b00000000000100,
      ST_DR50 = 14'b00000000001000,
      ST_DR95 = 14'b00000000010000,
      ST_CRD  = 14'b00000000100000,
      ST_CLD  = 14'b00000001000000,
      ST_SRD  = 14'b00000010000000,
      ST_SCMP = 14'b00000100000000,
      ST_SEL  = 14'b00001000000000,
      ST_MUL  = 14'b00010000000000,
      ST_DIVS = 14'b00100000000000,
      ST_DIVI = 14'b01000000000000,
      ST_EMIT = 14'b10000000000000
   } state_type;

endpackage
`default_nettype wire

/* rtl/ftpw_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Frame time percentile window channels
// Request, response and register write channels with valid/ready transfer.
// ----------------------------------------------------------------------------
interface ftpw_req_if;
   import ftpw_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [OP_W-1:0]       operation;
   logic [TIME_W-1:0]     cpu_total_time;
   logic [TIME_W-1:0]     cpu_present_time;
   logic [GPU_PASSES-1:0] gpu_valid_mask;
   logic [TIME_W-1:0]     gpu_time_0;
   logic [TIME_W-1:0]     gpu_time_1;
   logic [TIME_W-1:0]     gpu_time_2;
   logic [TIME_W-1:0]     gpu_time_3;
   logic [TIME_W-1:0]     gpu_time_4;
   logic [TIME_W-1:0]     gpu_time_5;
   logic [TIME_W-1:0]     gpu_time_6;
   logic [TIME_W-1:0]     gpu_time_7;
   modport source (output valid, operation, cpu_total_time, cpu_present_time, gpu_valid_mask,
                   gpu_time_0, gpu_time_1, gpu_time_2, gpu_time_3, gpu_time_4, gpu_time_5,
                   gpu_time_6, gpu_time_7, input ready);
   modport sink (input valid, operation, cpu_total_time, cpu_present_time, gpu_valid_mask,
                 gpu_time_0, gpu_time_1, gpu_time_2, gpu_time_3, gpu_time_4, gpu_time_5,
                 gpu_time_6, gpu_time_7, output ready);
endinterface

interface ftpw_rsp_if;
   import ftpw_pkg::*;
   logic              valid;
   logic              ready;
   logic [SER_W-1:0]  series_index;
   logic [TIME_W-1:0] median_time;
   logic [TIME_W-1:0] p95_time;
   logic              series_has_samples;
   logic [WARM_W-1:0] warmup_frames_done;
   logic [CNT_W-1:0]  sample_total;
   logic              window_complete;
   logic              last_result;
   modport source (output valid, series_index, median_time, p95_time, series_has_samples,
                   warmup_frames_done, sample_total, window_complete, last_result,
                   input ready);
   modport sink (input valid, series_index, median_time, p95_time, series_has_samples,
                 warmup_frames_done, sample_total, window_complete, last_result,
                 output ready);
endinterface

interface ftpw_csr_if;
   import ftpw_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* rtl/ftpw_div100.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Divide by one hundred
// Reciprocal multiply, then the remainder is recovered from the quotient; the
// product is registered first, then quotient, remainder and done together.
// ----------------------------------------------------------------------------
module ftpw_div100 (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        start,
   input  wire [ftpw_pkg::DIV_W-1:0]  dividend,
   output logic                       done,
   output logic [ftpw_pkg::DIV_W-1:0] quotient,
   output logic [ftpw_pkg::REM_W-1:0] remainder
);
   import ftpw_pkg::*;

   logic              pend_ff, pend_in;
   logic              done_ff, done_in;
   logic [DIV_W-1:0]  num_ff, num_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [DIV_W-1:0]  quo_ff, quo_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [DIV_W-1:0]  back;

   always_comb begin
      pend_in = start;
      done_in = pend_ff;
      num_in  = num_ff;
      prod_in = prod_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      back    = '0;
      if (start) begin
         num_in  = dividend;
         prod_in = PROD_W'(dividend) * PROD_W'(RECIP_MUL);
      end
      // take the high part, then recover the remainder from the quotient
      if (pend_ff) begin
         quo_in = DIV_W'(prod_ff >> RECIP_SHIFT);
         back   = DIV_W'(quo_in * DIV_W'(DIVISOR));
         rem_in = REM_W'(num_ff - back);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         pend_ff <= pend_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff  <= num_in;
      prod_ff <= prod_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule
`default_nettype wire

/* rtl/frame_time_percentile_window_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Frame time percentile window core
// Stores per-frame timings of ten series and reports interpolated 50th and
// 95th percentiles of each series on request.
// ----------------------------------------------------------------------------
// Observe: in warm-up or with the window closed only the request is taken;
//   otherwise one sample store write per series with a kept sample follows.
// Summarize: after accept, per series a rank-counting scan over all sample pairs
//   on the store's read port, then interpolation (an empty series skips both), then
//   the result waits for the response handshake; ten results, one request at a time.
// Reset: synchronous; counts, settings and state take defaults, data registers and store are not reset.
module frame_time_percentile_window_core (
   input wire         clock,
   input wire         reset,
   ftpw_req_if.sink   req_chan,
   ftpw_rsp_if.source rsp_chan,
   ftpw_csr_if.sink   csr_chan
);
   import ftpw_pkg::*;

   state_type           state_ff, state_in;
   logic [WARM_W-1:0]   warmup_ff, warmup_in;
   logic [CNT_W-1:0]    window_ff, window_in;
   logic [FRAME_W-1:0]  frames_ff, frames_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    gcnt_ff [GPU_PASSES];
   logic [CNT_W-1:0]    gcnt_in [GPU_PASSES];
   logic [SER_W-1:0]    ser_ff, ser_in;
   logic                isel_ff, isel_in;

   logic [TIME_W-1:0]     time_ff [SERIES];
   logic [TIME_W-1:0]     time_in [SERIES];
   logic [GPU_PASSES-1:0] mask_ff, mask_in;
   logic [CNT_W-1:0]      n_ff, n_in;
   logic [IDX_W-1:0]      rank_ff [RANKS];
   logic [IDX_W-1:0]      rank_in [RANKS];
   logic [TIME_W-1:0]     val_ff [RANKS];
   logic [TIME_W-1:0]     val_in [RANKS];
   logic [REM_W-1:0]      rem50_ff, rem50_in, rem95_ff, rem95_in;
   logic [TIME_W-1:0]     cand_ff, cand_in;
   logic [CNT_W-1:0]      ci_ff, ci_in, sj_ff, sj_in, lt_ff, lt_in, le_ff, le_in;
   logic [DIV_W-1:0]      prod_ff, prod_in;
   logic [TIME_W-1:0]     p50_ff, p50_in, p95_ff, p95_in;
   logic                  has_ff, has_in;

   logic [TIME_W-1:0] store_mem [STORE_DEPTH];
   logic [TIME_W-1:0] rd_data_ff;
   logic [ADDR_W-1:0] rd_addr, wr_addr;
   logic              wr_en;

   logic              div_start, div_done;
   logic [DIV_W-1:0]  div_dividend, div_quo;
   logic [REM_W-1:0]  div_rem;

   logic [SER_W-1:0]  gsub;
   logic [2:0]        gidx;
   logic [CNT_W-1:0]  series_n;
   logic [IDX_W-1:0]  wr_idx;
   logic [SCALED_W-1:0] sc50, sc95;
   logic [IDX_W-1:0]  div_lo, div_hi;
   logic [TIME_W-1:0] lo_val, hi_val, diff;
   logic [REM_W-1:0]  frac;
   logic [TIME_W-1:0] interp;
   logic              req_xfer, rsp_xfer;

   ftpw_div100 u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign csr_chan.ready = 1'b1;
   assign req_xfer       = req_chan.valid && req_chan.ready;
   assign rsp_xfer       = rsp_chan.valid && rsp_chan.ready;

   assign gsub     = ser_ff - SER_W'(2);
   assign gidx     = gsub[2:0];
   assign series_n = (ser_ff < SER_W'(2)) ? count_ff : gcnt_ff[gidx];
   assign wr_idx   = series_n[IDX_W-1:0];
   assign wr_en    = (state_ff == ST_OBS) &&
                     ((ser_ff < SER_W'(2)) ||
                      (mask_ff[gidx] && (gcnt_ff[gidx] < CNT_W'(MAX_SAMPLES))));
   assign wr_addr  = {ser_ff, wr_idx};
   assign rd_addr  = (state_ff == ST_CRD) ? {ser_ff, ci_ff[IDX_W-1:0]}
                                          : {ser_ff, sj_ff[IDX_W-1:0]};

   assign sc50 = SCALED_W'(series_n - CNT_W'(1)) * SCALED_W'(PCT_MED);
   assign sc95 = SCALED_W'(n_ff - CNT_W'(1)) * SCALED_W'(PCT_HIGH);

   // upper rank: one past the lower one, clamped to the last sample
   assign div_lo = div_quo[IDX_W-1:0];
   assign div_hi = (({1'b0, div_lo} + CNT_W'(1)) < n_ff) ? div_lo + IDX_W'(1)
                                                         : IDX_W'(n_ff - CNT_W'(1));

   assign lo_val = isel_ff ? val_ff[2] : val_ff[0];
   assign hi_val = isel_ff ? val_ff[3] : val_ff[1];
   assign frac   = isel_ff ? rem95_ff : rem50_ff;
   assign diff   = hi_val - lo_val;
   assign interp = lo_val + div_quo[TIME_W-1:0];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= time_ff[ser_ff];
      end
      rd_data_ff <= store_mem[rd_addr];
   end

   always_comb begin
      state_in     = state_ff;
      warmup_in    = warmup_ff;
      window_in    = window_ff;
      frames_in    = frames_ff;
      count_in     = count_ff;
      gcnt_in      = gcnt_ff;
      ser_in       = ser_ff;
      isel_in      = isel_ff;
      time_in      = time_ff;
      mask_in      = mask_ff;
      n_in         = n_ff;
      rank_in      = rank_ff;
      val_in       = val_ff;
      rem50_in     = rem50_ff;
      rem95_in     = rem95_ff;
      cand_in      = cand_ff;
      ci_in        = ci_ff;
      sj_in        = sj_ff;
      lt_in        = lt_ff;
      le_in        = le_ff;
      prod_in      = prod_ff;
      p50_in       = p50_ff;
      p95_in       = p95_ff;
      has_in       = has_ff;
      div_start    = 1'b0;
      div_dividend = DIV_W'(sc50);

      if (csr_chan.valid && csr_chan.ready) begin
         unique case (csr_chan.index)
            CSR_WARMUP: warmup_in = csr_chan.data;
            CSR_WINDOW: window_in = csr_chan.data[CNT_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               unique case (req_chan.operation)
                  OP_OBSERVE: begin
                     if (frames_ff < {1'b0, warmup_ff}) begin
                        frames_in = frames_ff + FRAME_W'(1);
                     end else if ((window_ff != '0) && (count_ff < window_ff) &&
                                  (count_ff < CNT_W'(MAX_SAMPLES))) begin
                        time_in[0] = req_chan.cpu_total_time;
                        time_in[1] = req_chan.cpu_present_time;
                        time_in[2] = req_chan.gpu_time_0;
                        time_in[3] = req_chan.gpu_time_1;
                        time_in[4] = req_chan.gpu_time_2;
                        time_in[5] = req_chan.gpu_time_3;
                        time_in[6] = req_chan.gpu_time_4;
                        time_in[7] = req_chan.gpu_time_5;
                        time_in[8] = req_chan.gpu_time_6;
                        time_in[9] = req_chan.gpu_time_7;
                        mask_in    = req_chan.gpu_valid_mask;
                        ser_in     = '0;
                        state_in   = ST_OBS;
                     end
                  end
                  OP_SUMMARIZE: begin
                     ser_in   = '0;
                     state_in = ST_SER;
                  end
                  OP_CLEAR: begin
                     frames_in = '0;
                     count_in  = '0;
                     for (int k = 0; k < GPU_PASSES; k++) begin
                        gcnt_in[k] = '0;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_OBS: begin
            if (wr_en && (ser_ff >= SER_W'(2))) begin
               gcnt_in[gidx] = gcnt_ff[gidx] + CNT_W'(1);
            end
            if (ser_ff == SER_W'(SERIES - 1)) begin
               count_in  = count_ff + CNT_W'(1);
               frames_in = frames_ff + FRAME_W'(1);
               state_in  = ST_IDLE;
            end else begin
               ser_in = ser_ff + SER_W'(1);
            end
         end
         ST_SER: begin
            n_in = series_n;
            if (series_n == '0) begin
               p50_in   = '0;
               p95_in   = '0;
               has_in   = 1'b0;
               state_in = ST_EMIT;
            end else begin
               div_start = 1'b1;
               state_in  = ST_DR50;
            end
         end
         ST_DR50: begin
            div_dividend = DIV_W'(sc95);
            if (div_done) begin
               rank_in[0] = div_lo;
               rank_in[1] = div_hi;
               rem50_in   = div_rem;
               div_start  = 1'b1;
               state_in   = ST_DR95;
            end
         end
         ST_DR95: begin
            if (div_done) begin
               rank_in[2] = div_lo;
               rank_in[3] = div_hi;
               rem95_in   = div_rem;
               ci_in      = '0;
               state_in   = ST_CRD;
            end
         end
         ST_CRD: begin
            state_in = ST_CLD;
         end
         ST_CLD: begin
            cand_in  = rd_data_ff;
            sj_in    = '0;
            lt_in    = '0;
            le_in    = '0;
            state_in = ST_SRD;
         end
         ST_SRD: begin
            state_in = ST_SCMP;
         end
         ST_SCMP: begin
            if (rd_data_ff < cand_ff) begin
               lt_in = lt_ff + CNT_W'(1);
               le_in = le_ff + CNT_W'(1);
            end else if (rd_data_ff == cand_ff) begin
               le_in = le_ff + CNT_W'(1);
            end
            sj_in    = sj_ff + CNT_W'(1);
            state_in = ((sj_ff + CNT_W'(1)) == n_ff) ? ST_SEL : ST_SRD;
         end
         ST_SEL: begin
            // the candidate fills every rank that falls among its equal run
            for (int r = 0; r < RANKS; r++) begin
               if ((lt_ff <= {1'b0, rank_ff[r]}) && ({1'b0, rank_ff[r]} < le_ff)) begin
                  val_in[r] = cand_ff;
               end
            end
            ci_in = ci_ff + CNT_W'(1);
            if ((ci_ff + CNT_W'(1)) == n_ff) begin
               isel_in  = 1'b0;
               state_in = ST_MUL;
            end else begin
               state_in = ST_CRD;
            end
         end
         ST_MUL: begin
            prod_in  = DIV_W'(diff) * DIV_W'(frac);
            state_in = ST_DIVS;
         end
         ST_DIVS: begin
            div_dividend = prod_ff;
            div_start    = 1'b1;
            state_in     = ST_DIVI;
         end
         ST_DIVI: begin
            if (div_done) begin
               if (!isel_ff) begin
                  p50_in   = interp;
                  isel_in  = 1'b1;
                  state_in = ST_MUL;
               end else begin
                  p95_in   = interp;
                  has_in   = 1'b1;
                  state_in = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            if (rsp_xfer) begin
               if (ser_ff == SER_W'(SERIES - 1)) begin
                  state_in = ST_IDLE;
               end else begin
                  ser_in   = ser_ff + SER_W'(1);
                  state_in = ST_SER;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         warmup_ff <= '0;
         window_ff <= CNT_W'(MAX_SAMPLES);
         frames_ff <= '0;
         count_ff  <= '0;
         ser_ff    <= '0;
         isel_ff   <= 1'b0;
         for (int k = 0; k < GPU_PASSES; k++) begin
            gcnt_ff[k] <= '0;
         end
      end else begin
         state_ff  <= state_in;
         warmup_ff <= warmup_in;
         window_ff <= window_in;
         frames_ff <= frames_in;
         count_ff  <= count_in;
         ser_ff    <= ser_in;
         isel_ff   <= isel_in;
         gcnt_ff   <= gcnt_in;
      end
   end

   always_ff @(posedge clock) begin
      time_ff  <= time_in;
      mask_ff  <= mask_in;
      n_ff     <= n_in;
      rank_ff  <= rank_in;
      val_ff   <= val_in;
      rem50_ff <= rem50_in;
      rem95_ff <= rem95_in;
      cand_ff  <= cand_in;
      ci_ff    <= ci_in;
      sj_ff    <= sj_in;
      lt_ff    <= lt_in;
      le_ff    <= le_in;
      prod_ff  <= prod_in;
      p50_ff   <= p50_in;
      p95_ff   <= p95_in;
      has_ff   <= has_in;
   end

   assign rsp_chan.valid              = (state_ff == ST_EMIT);
   assign rsp_chan.series_index       = ser_ff;
   assign rsp_chan.median_time        = p50_ff;
   assign rsp_chan.p95_time           = p95_ff;
   assign rsp_chan.series_has_samples = has_ff;
   assign rsp_chan.warmup_frames_done = (frames_ff < {1'b0, warmup_ff}) ? frames_ff[WARM_W-1:0]
                                                                        : warmup_ff;
   assign rsp_chan.sample_total       = count_ff;
   assign rsp_chan.window_complete    = (window_ff != '0) && (count_ff >= window_ff);
   assign rsp_chan.last_result        = (ser_ff == SER_W'(SERIES - 1));

   a_no_rsp_while_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> !req_chan.ready)
      else $error("response offered while accepting requests");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_SAMPLES))
      else $error("sample count beyond storage");

   a_div_done_expected: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DR50 || state_ff == ST_DR95 || state_ff == ST_DIVI))
      else $error("divider finished outside a wait state");

   a_series_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (ser_ff < SER_W'(SERIES)))
      else $error("series index out of range");

endmodule
`default_nettype wire

/* tb/sv/frame_time_percentile_window_core_test.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Frame time percentile window core test
// Drives frames, summaries and clears through the request channel under
// several warm-up and window settings, predicts each series summary with a
// local model of the sample window and checks every response field by field.
// ----------------------------------------------------------------------------
module frame_time_percentile_window_core_test;
   import ftpw_pkg::*;

   typedef struct {
      logic [OP_W-1:0]   op_raw;
      logic [TIME_W-1:0] cpu_total;
      logic [TIME_W-1:0] cpu_present;
      logic [7:0]        mask;
      logic [TIME_W-1:0] gpu [8];
      bit                empty_known;
   } frame_item_type;

   typedef struct packed {
      logic [SER_W-1:0]  series;
      logic [TIME_W-1:0] median;
      logic [TIME_W-1:0] p95;
      logic              has_samples;
      logic [WARM_W-1:0] warm_done;
      logic [CNT_W-1:0]  collected;
      logic              complete;
      logic              last;
   } series_summary_type;

   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam logic [TIME_W-1:0] TIME_MAX = 24'hFFFFFF;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ftpw_req_if req_bus ();
   ftpw_rsp_if rsp_bus ();
   ftpw_csr_if csr_bus ();

   frame_time_percentile_window_core DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // window model
   logic [WARM_W-1:0]  warm_cfg;
   logic [CNT_W-1:0]   window_cfg;
   logic [FRAME_W-1:0] frames_seen;
   logic [CNT_W-1:0]   sample_cnt;
   logic [CNT_W-1:0]   gpu_cnt [8];
   logic [TIME_W-1:0]  total_store [MAX_SAMPLES];
   logic [TIME_W-1:0]  present_store [MAX_SAMPLES];
   logic [TIME_W-1:0]  gpu_store [8][MAX_SAMPLES];
   logic [TIME_W-1:0]  sort_buf [MAX_SAMPLES];

   series_summary_type expected_summaries[$];
   int  fail_count = 0;
   bit  quiet = 1'b0;
   int  rsp_hold = 0;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      fail_count++;
   endtask

   task automatic queue_summary(input series_summary_type r);
      expected_summaries.insert(expected_summaries.size(), r);
   endtask

   function automatic logic [TIME_W-1:0] interpolate(input int n, input int pct);
      int          scaled;
      int          lo;
      int          rem;
      int          hi;
      longint      diff;
      scaled = pct * (n - 1);
      lo     = scaled / 100;
      rem    = scaled % 100;
      hi     = (lo + 1 < n) ? lo + 1 : n - 1;
      diff   = longint'(sort_buf[hi]) - longint'(sort_buf[lo]);
      return sort_buf[lo] + TIME_W'((diff * rem) / 100);
   endfunction

   task automatic summarize_into_queue();
      series_summary_type r;
      int              n;
      int              i;
      int              j;
      logic [TIME_W-1:0] v;
      for (int s = 0; s < SERIES; s++) begin
         n = (s < 2) ? int'(sample_cnt) : int'(gpu_cnt[s-2]);
         for (i = 0; i < n; i++)
            sort_buf[i] = (s == 0) ? total_store[i] :
                          (s == 1) ? present_store[i] : gpu_store[s-2][i];
         for (i = 1; i < n; i++) begin
            v = sort_buf[i];
            j = i;
            while (j > 0 && sort_buf[j-1] > v) begin
               sort_buf[j] = sort_buf[j-1];
               j--;
            end
            sort_buf[j] = v;
         end
         r.series      = SER_W'(s);
         r.median      = (n == 0) ? '0 : interpolate(n, PCT_MED);
         r.p95         = (n == 0) ? '0 : interpolate(n, PCT_HIGH);
         r.has_samples = (n != 0);
         r.warm_done   = (frames_seen < warm_cfg) ? WARM_W'(frames_seen) : warm_cfg;
         r.collected   = sample_cnt;
         r.complete    = (window_cfg != 0) && (sample_cnt >= window_cfg);
         r.last        = (s == SERIES - 1);
         queue_summary(r);
      end
   endtask

   task automatic apply_frame(input frame_item_type it);
      series_summary_type r;
      case (it.op_raw)
         OP_OBSERVE: begin
            if (frames_seen < warm_cfg) begin
               frames_seen++;
            end else if (window_cfg != 0 && sample_cnt < window_cfg
                         && sample_cnt < MAX_SAMPLES) begin
               total_store[sample_cnt]   = it.cpu_total;
               present_store[sample_cnt] = it.cpu_present;
               for (int k = 0; k < GPU_PASSES; k++)
                  if (it.mask[k] && gpu_cnt[k] < MAX_SAMPLES) begin
                     gpu_store[k][gpu_cnt[k]] = it.gpu[k];
                     gpu_cnt[k]++;
                  end
               sample_cnt++;
               frames_seen++;
            end
         end
         OP_SUMMARIZE: begin
            if (it.empty_known) begin
               // empty window straight after reset or clear: all zeros
               for (int s = 0; s < SERIES; s++) begin
                  r = '0;
                  r.series = SER_W'(s);
                  r.last   = (s == SERIES - 1);
                  queue_summary(r);
               end
            end else begin
               summarize_into_queue();
            end
         end
         OP_CLEAR: begin
            frames_seen = '0;
            sample_cnt  = '0;
            for (int k = 0; k < GPU_PASSES; k++) gpu_cnt[k] = '0;
         end
         default: ;
      endcase
   endtask

   task automatic send_frame(input frame_item_type it);
      req_bus.valid            <= 1'b1;
      req_bus.operation        <= it.op_raw;
      req_bus.cpu_total_time   <= it.cpu_total;
      req_bus.cpu_present_time <= it.cpu_present;
      req_bus.gpu_valid_mask   <= it.mask;
      req_bus.gpu_time_0       <= it.gpu[0];
      req_bus.gpu_time_1       <= it.gpu[1];
      req_bus.gpu_time_2       <= it.gpu[2];
      req_bus.gpu_time_3       <= it.gpu[3];
      req_bus.gpu_time_4       <= it.gpu[4];
      req_bus.gpu_time_5       <= it.gpu[5];
      req_bus.gpu_time_6       <= it.gpu[6];
      req_bus.gpu_time_7       <= it.gpu[7];
      do @(negedge clock); while (!req_bus.ready);
      @(posedge clock);
      apply_frame(it);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
   endtask

   // hold until every summary is back, then let an observe finish
   task automatic drain();
      req_bus.valid <= 1'b0;
      while (expected_summaries.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= data;
      do @(negedge clock); while (!csr_bus.ready);
      @(posedge clock);
      csr_bus.valid <= 1'b0;
      if (idx == CSR_WARMUP) warm_cfg = data;
      else if (idx == CSR_WINDOW) window_cfg = data[CNT_W-1:0];
      @(posedge clock);
   endtask

   function automatic logic [TIME_W-1:0] rand_time();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return TIME_MAX;
         2:       return TIME_W'($urandom_range(0, 15));
         3:       return TIME_W'($urandom_range(4000, 4200));
         default: return TIME_W'($urandom);
      endcase
   endfunction

   function automatic frame_item_type make_frame(input logic [OP_W-1:0] op,
                                                 input logic [TIME_W-1:0] t,
                                                 input logic [7:0] mask, input bit empty);
      frame_item_type it;
      it.op_raw      = op;
      it.cpu_total   = t;
      it.cpu_present = ~t;
      it.mask        = mask;
      for (int k = 0; k < 8; k++) it.gpu[k] = t ^ TIME_W'(k * 24'h111111);
      it.empty_known = empty;
      return it;
   endfunction

   function automatic frame_item_type random_frame();
      frame_item_type it;
      int          pick;
      pick = $urandom_range(0, 99);
      it = make_frame(OP_OBSERVE, rand_time(), 8'($urandom), 1'b0);
      it.cpu_present = rand_time();
      for (int k = 0; k < 8; k++) it.gpu[k] = rand_time();
      if (pick < 9) it.op_raw = OP_SUMMARIZE;
      else if (pick < 14) it.op_raw = OP_CLEAR;
      else if (pick < 17) it.op_raw = OP_UNUSED;
      // keep sort sizes small so summaries stay short
      if (sample_cnt >= 30 && it.op_raw == OP_OBSERVE) it.op_raw = OP_CLEAR;
      return it;
   endfunction

   // result side: transfer is decided by the levels held over the low phase
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rsp_hold      <= 0;
      end else if (rsp_hold > 0) begin
         rsp_hold <= rsp_hold - 1;
      end else if (!quiet && rsp_bus.ready && $urandom_range(0, 6) == 0) begin
         rsp_bus.ready <= 1'b0;
         rsp_hold      <= $urandom_range(0, 12);
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   always @(negedge clock) begin
      series_summary_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_summaries.size() == 0) begin
            report_mismatch("unexpected result, series", 32'(rsp_bus.series_index), 32'd0);
         end else begin
            want = expected_summaries.pop_front();
            if (rsp_bus.series_index !== want.series)
               report_mismatch("series_index", rsp_bus.series_index, want.series);
            if (rsp_bus.median_time !== want.median)
               report_mismatch("median_time", rsp_bus.median_time, want.median);
            if (rsp_bus.p95_time !== want.p95)
               report_mismatch("p95_time", rsp_bus.p95_time, want.p95);
            if (rsp_bus.series_has_samples !== want.has_samples)
               report_mismatch("series_has_samples", rsp_bus.series_has_samples,
                               want.has_samples);
            if (rsp_bus.warmup_frames_done !== want.warm_done)
               report_mismatch("warmup_frames_done", rsp_bus.warmup_frames_done,
                               want.warm_done);
            if (rsp_bus.sample_total !== want.collected)
               report_mismatch("sample_total", rsp_bus.sample_total,
                               want.collected);
            if (rsp_bus.window_complete !== want.complete)
               report_mismatch("window_complete", rsp_bus.window_complete, want.complete);
            if (rsp_bus.last_result !== want.last)
               report_mismatch("last_result", rsp_bus.last_result, want.last);
         end
      end
   end

   initial begin
      #200000000;
      $display("Verification failed");
      $finish;
   end

   initial begin
      frame_item_type stim_table[$];
      frame_item_type it;
      int          phase_items;
      int          sent;
      int          wait_cycles;
      logic [CNT_W-1:0] win;

      req_bus.valid            = 1'b0;
      req_bus.operation        = OP_OBSERVE;
      req_bus.cpu_total_time   = '0;
      req_bus.cpu_present_time = '0;
      req_bus.gpu_valid_mask   = '0;
      req_bus.gpu_time_0       = '0;
      req_bus.gpu_time_1       = '0;
      req_bus.gpu_time_2       = '0;
      req_bus.gpu_time_3       = '0;
      req_bus.gpu_time_4       = '0;
      req_bus.gpu_time_5       = '0;
      req_bus.gpu_time_6       = '0;
      req_bus.gpu_time_7       = '0;
      csr_bus.valid            = 1'b0;
      csr_bus.index            = CSR_WARMUP;
      csr_bus.data             = '0;
      warm_cfg    = '0;
      window_cfg  = CNT_W'(MAX_SAMPLES);
      frames_seen = '0;
      sample_cnt  = '0;
      for (int k = 0; k < 8; k++) gpu_cnt[k] = '0;

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rows under reset settings
      stim_table.insert(stim_table.size(), make_frame(OP_SUMMARIZE, '0, 8'h00, 1'b1));
      stim_table.insert(stim_table.size(), make_frame(OP_UNUSED, TIME_MAX, 8'hFF, 1'b0));
      stim_table.insert(stim_table.size(), make_frame(OP_SUMMARIZE, '0, 8'h00, 1'b1));
      stim_table.insert(stim_table.size(), make_frame(OP_OBSERVE, TIME_MAX, 8'hFF, 1'b0));
      stim_table.insert(stim_table.size(), make_frame(OP_SUMMARIZE, '0, 8'h00, 1'b0));
      stim_table.insert(stim_table.size(), make_frame(OP_OBSERVE, '0, 8'h00, 1'b0));
      stim_table.insert(stim_table.size(), make_frame(OP_OBSERVE, 24'h123456, 8'h55, 1'b0));
      stim_table.insert(stim_table.size(), make_frame(OP_OBSERVE, 24'h800000, 8'hAA, 1'b0));
      stim_table.insert(stim_table.size(), make_frame(OP_OBSERVE, 24'h000001, 8'h81, 1'b0));
      stim_table.insert(stim_table.size(), make_frame(OP_OBSERVE, 24'h7FFFFF, 8'h7E, 1'b0));
      stim_table.insert(stim_table.size(), make_frame(OP_OBSERVE, 24'h000100, 8'hFF, 1'b0));
      stim_table.insert(stim_table.size(), make_frame(OP_SUMMARIZE, '0, 8'h00, 1'b0));
      stim_table.insert(stim_table.size(), make_frame(OP_CLEAR, TIME_MAX, 8'hFF, 1'b0));
      stim_table.insert(stim_table.size(), make_frame(OP_SUMMARIZE, '0, 8'h00, 1'b1));
      stim_table.insert(stim_table.size(), make_frame(OP_OBSERVE, 24'h000200, 8'h01, 1'b0));
      stim_table.insert(stim_table.size(), make_frame(OP_OBSERVE, 24'h000200, 8'h01, 1'b0));
      stim_table.insert(stim_table.size(), make_frame(OP_OBSERVE, 24'h000100, 8'h03, 1'b0));
      stim_table.insert(stim_table.size(), make_frame(OP_SUMMARIZE, '0, 8'h00, 1'b0));
      foreach (stim_table[i]) send_frame(stim_table[i]);
      drain();

      // extreme settings: long warm-up, closed window, shrink below held samples
      write_csr(CSR_WARMUP, 16'hFFFF);
      for (int i = 0; i < 4; i++) send_frame(random_frame());
      send_frame(make_frame(OP_SUMMARIZE, '0, 8'h00, 1'b0));
      drain();
      write_csr(CSR_WARMUP, 16'd0);
      write_csr(CSR_WINDOW, 16'd0);
      send_frame(make_frame(OP_CLEAR, '0, 8'h00, 1'b0));
      for (int i = 0; i < 3; i++) send_frame(make_frame(OP_OBSERVE, TIME_MAX, 8'hFF, 1'b0));
      send_frame(make_frame(OP_SUMMARIZE, '0, 8'h00, 1'b0));
      drain();
      write_csr(CSR_WINDOW, 16'd8);
      for (int i = 0; i < 6; i++) send_frame(make_frame(OP_OBSERVE, rand_time(), 8'($urandom), 1'b0));
      drain();
      write_csr(CSR_WINDOW, 16'd2);
      send_frame(make_frame(OP_OBSERVE, TIME_MAX, 8'hFF, 1'b0));
      send_frame(make_frame(OP_SUMMARIZE, '0, 8'h00, 1'b0));
      drain();

      // random phases, each with its own settings
      sent = 0;
      while (sent < 450) begin
         if (sent >= 390) quiet = 1'b1;
         case ($urandom_range(0, 5))
            0:       write_csr(CSR_WARMUP, 16'($urandom_range(0, 6)));
            1:       write_csr(CSR_WARMUP, 16'($urandom));
            default: write_csr(CSR_WARMUP, 16'($urandom_range(0, 2)));
         endcase
         case ($urandom_range(0, 7))
            0:       win = CNT_W'(MAX_SAMPLES);
            1:       win = '0;
            2:       win = 9'd1;
            default: win = CNT_W'($urandom_range(2, 24));
         endcase
         write_csr(CSR_WINDOW, {7'($urandom), win});
         if ($urandom_range(0, 2) != 0) begin
            send_frame(make_frame(OP_CLEAR, '0, 8'h00, 1'b0));
            sent++;
         end
         phase_items = $urandom_range(20, 60);
         for (int i = 0; i < phase_items; i++) begin
            it = random_frame();
            send_frame(it);
            sent++;
         end
         send_frame(make_frame(OP_SUMMARIZE, '0, 8'h00, 1'b0));
         sent++;
         drain();
      end

      wait_cycles = 0;
      while (expected_summaries.size() != 0 && wait_cycles < 2000000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (50) @(posedge clock);
      if (fail_count == 0 && expected_summaries.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
`default_nettype wire

/* filelist.f */
rtl/ftpw_pkg.sv
rtl/ftpw_if.sv
rtl/ftpw_div100.sv
rtl/frame_time_percentile_window_core.sv
tb/sv/frame_time_percentile_window_core_test.sv
